// ----- sv/dkpu_pkg.sv -----
package dkpu_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Datapath operations, one per control word
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_LOAD,
    OP_DIV,
    OP_MULI,
    OP_MUL,
    OP_WB,
    OP_OUT
  } op_e;

  // Sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_IN,
    C_COUNT,
    C_MORE,
    C_OUT
  } cond_e;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_e;

  typedef enum logic [1:0] {
    REG_XY_NOISE,
    REG_Z_NOISE,
    REG_INIT_VAR
  } reg_e;

  localparam int UC_DEPTH = 7;
  typedef logic [2:0] upc_t;

  localparam upc_t PC_WAIT = 3'd0;
  localparam upc_t PC_LOAD = 3'd1;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
  } ucode_t;

  // Per axis: load, divide, set up multiply, multiply, write back.
  localparam ucode_t UCODE [UC_DEPTH] = '{
    '{OP_WAIT, C_IN,    PC_WAIT},
    '{OP_LOAD, C_NEXT,  PC_WAIT},
    '{OP_DIV,  C_COUNT, PC_WAIT},
    '{OP_MULI, C_NEXT,  PC_WAIT},
    '{OP_MUL,  C_COUNT, PC_WAIT},
    '{OP_WB,   C_MORE,  PC_LOAD},
    '{OP_OUT,  C_OUT,   PC_WAIT}
  };

  typedef struct packed {
    op_e  op;
    logic first;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic more;
    logic out_busy;
  } status_t;

endpackage

// ----- sv/diagonal_kalman_position_update.sv -----
// Per-axis scalar Kalman measurement update for x, y and z position.
// Input stream: s_axis_tuser carries the mode (0 GPS updates x and y, 1 depth
// updates z); s_axis_tdata carries gps_x, gps_y, depth_m. Every input
// transaction yields one output transaction on m_axis_tdata with the three
// position estimates after the update.
// Sequencing: a microcoded sequencer steps one shared datapath; each axis
// runs one restoring-divider step per gain bit, then one shift-add step per
// gain bit for the estimate and variance products. A depth item runs these
// steps for z alone, a GPS item for x and then y, between the accept step
// and the output load.
// The result sits in an output register, so the next item is accepted while
// a result waits; if the receiver stalls, the block holds at the output load
// step of the following item until the register frees up.
// Configuration (APB): x/y noise, z noise, initial variance; writing the
// initial variance also loads all three variances. Write only while idle.
// Reset: estimates go to zero, variances and noises to 1.0.
module diagonal_kalman_position_update #(
  parameter int FRAC_BITS   = dkpu_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = dkpu_pkg::VALUE_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // APB configuration port
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [((VALUE_WIDTH > 32) ? 5 : 4)-1:0]   paddr,
  input  logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic                                      pready,
  // input stream
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // tdata: gps_x, gps_y, depth_m (lowest first), zero-padded to bytes
  input  logic [((3*VALUE_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  // tuser: mode
  input  logic                                      s_axis_tuser,
  // output stream
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // tdata: pos_x, pos_y, pos_z (lowest first), zero-padded to bytes
  output logic [((3*VALUE_WIDTH+7)/8)*8-1:0]        m_axis_tdata
);
  import dkpu_pkg::*;

  localparam int W   = VALUE_WIDTH;
  localparam int PDW = (W > 32) ? 64 : 32;
  localparam int AW  = (W > 32) ? 5 : 4;
  localparam int SL  = (W > 32) ? 3 : 2;
  localparam int DW  = ((3 * W + 7) / 8) * 8;

  logic [W-1:0] xy_noise_q, z_noise_q, init_var_q;
  logic         wr_fire;
  reg_e         wr_idx;
  logic         var_load;
  logic [W-1:0] rd_val;

  ctrl_t        ctrl;
  status_t      status;
  logic         in_fire;
  logic         more, out_busy;
  logic [W-1:0] pos_x, pos_y, pos_z;

  assign pready   = 1'b1;
  assign wr_fire  = psel && penable && pwrite && pready;
  assign wr_idx   = reg_e'(paddr[AW-1:SL]);
  assign var_load = wr_fire && (wr_idx == REG_INIT_VAR);

  always_comb begin
    case (wr_idx)
      REG_XY_NOISE: rd_val = xy_noise_q;
      REG_Z_NOISE:  rd_val = z_noise_q;
      REG_INIT_VAR: rd_val = init_var_q;
      default:      rd_val = '0;
    endcase
  end
  assign prdata = PDW'(rd_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xy_noise_q <= W'(1) << FRAC_BITS;
      z_noise_q  <= W'(1) << FRAC_BITS;
      init_var_q <= W'(1) << FRAC_BITS;
    end else if (wr_fire) begin
      case (wr_idx)
        REG_XY_NOISE: xy_noise_q <= pwdata[W-1:0];
        REG_Z_NOISE:  z_noise_q  <= pwdata[W-1:0];
        REG_INIT_VAR: init_var_q <= pwdata[W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = (ctrl.op == OP_WAIT);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign status.in_fire  = in_fire;
  assign status.more     = more;
  assign status.out_busy = out_busy;

  dkpu_seq #(
    .FRAC_BITS(FRAC_BITS)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .ctrl_o  (ctrl)
  );

  dkpu_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_fire_i  (in_fire),
    .mode_i     (s_axis_tuser),
    .gps_x_i    (s_axis_tdata[W-1:0]),
    .gps_y_i    (s_axis_tdata[2*W-1:W]),
    .depth_m_i  (s_axis_tdata[3*W-1:2*W]),
    .xy_noise_i (xy_noise_q),
    .z_noise_i  (z_noise_q),
    .var_load_i (var_load),
    .var_value_i(pwdata[W-1:0]),
    .out_ready_i(m_axis_tready),
    .more_o     (more),
    .out_busy_o (out_busy),
    .out_valid_o(m_axis_tvalid),
    .pos_x_o    (pos_x),
    .pos_y_o    (pos_y),
    .pos_z_o    (pos_z)
  );

  assign m_axis_tdata = DW'({pos_z, pos_y, pos_x});

endmodule

// ----- sv/dkpu_seq.sv -----
module dkpu_seq #(
  parameter int FRAC_BITS = dkpu_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dkpu_pkg::status_t status_i,
  output dkpu_pkg::ctrl_t   ctrl_o
);
  import dkpu_pkg::*;

  localparam int CW = $clog2(FRAC_BITS + 1);

  upc_t          pc_q, pc_d;
  logic [CW-1:0] cnt_q, cnt_d;
  ucode_t        uc;

  assign uc           = UCODE[pc_q];
  assign ctrl_o.op    = uc.op;
  assign ctrl_o.first = (cnt_q == '0);

  always_comb begin
    pc_d  = pc_q;
    cnt_d = cnt_q;
    case (uc.cond)
      C_NEXT: pc_d = upc_t'(pc_q + 3'd1);
      C_IN: begin
        if (status_i.in_fire) pc_d = upc_t'(pc_q + 3'd1);
      end
      C_COUNT: begin
        // repeat this step FRAC_BITS+1 times
        if (cnt_q == CW'(FRAC_BITS)) begin
          cnt_d = '0;
          pc_d  = upc_t'(pc_q + 3'd1);
        end else begin
          cnt_d = CW'(cnt_q + 1'b1);
        end
      end
      C_MORE: pc_d = status_i.more ? uc.target : upc_t'(pc_q + 3'd1);
      C_OUT: begin
        if (!status_i.out_busy) pc_d = uc.target;
      end
      default: pc_d = PC_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= PC_WAIT;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- sv/dkpu_dp.sv -----
module dkpu_dp #(
  parameter int FRAC_BITS   = dkpu_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = dkpu_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dkpu_pkg::ctrl_t        ctrl_i,
  input  logic                   in_fire_i,
  input  logic                   mode_i,
  input  logic [VALUE_WIDTH-1:0] gps_x_i,
  input  logic [VALUE_WIDTH-1:0] gps_y_i,
  input  logic [VALUE_WIDTH-1:0] depth_m_i,
  input  logic [VALUE_WIDTH-1:0] xy_noise_i,
  input  logic [VALUE_WIDTH-1:0] z_noise_i,
  input  logic                   var_load_i,
  input  logic [VALUE_WIDTH-1:0] var_value_i,
  input  logic                   out_ready_i,
  output logic                   more_o,
  output logic                   out_busy_o,
  output logic                   out_valid_o,
  output logic [VALUE_WIDTH-1:0] pos_x_o,
  output logic [VALUE_WIDTH-1:0] pos_y_o,
  output logic [VALUE_WIDTH-1:0] pos_z_o
);
  import dkpu_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = W + F + 2;

  localparam logic [W-1:0] ONE_W = W'(1) << F;
  localparam logic [F:0]   ONE_G = (F + 1)'(1) << F;

  logic [W-1:0]  est_q [3];
  logic [W-1:0]  var_q [3];
  logic [W-1:0]  meas_q [3];
  axis_e         axis_q;
  logic          out_valid_q;
  logic [W-1:0]  pos_x_q, pos_y_q, pos_z_q;

  logic [W:0]    den_q;
  logic [W+1:0]  rem_q;
  logic [F:0]    quo_q;
  logic [W:0]    mag_q;
  logic          neg_q;
  logic [F:0]    ga_q, gb_q;
  logic [PW-1:0] acc_e_q, acc_v_q;

  logic [W-1:0]  cur_est, cur_var, cur_meas, noise;
  logic [W:0]    res, mag;
  logic [W+1:0]  rem_sh, rem_nx;
  logic          ge;
  logic [F:0]    gain;
  logic [PW-1:0] acc_e_nx, acc_v_nx;
  logic [W:0]    delta, est_w;
  logic [W-1:0]  var_new;

  assign cur_est  = est_q[axis_q];
  assign cur_var  = var_q[axis_q];
  assign cur_meas = meas_q[axis_q];
  assign noise    = (axis_q == AX_Z) ? z_noise_i : xy_noise_i;

  // residual and its magnitude, W+1 bits so it cannot wrap
  assign res = {cur_meas[W-1], cur_meas} - {cur_est[W-1], cur_est};
  assign mag = res[W] ? (W + 1)'(-res) : res;

  // restoring divider step; the first step compares without a shift
  assign rem_sh = ctrl_i.first ? rem_q : {rem_q[W:0], 1'b0};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign rem_nx = ge ? (W + 2)'(rem_sh - {1'b0, den_q}) : rem_sh;

  assign gain = (den_q == '0) ? '0 : quo_q;

  // MSB-first shift-add multipliers, one gain bit per step
  assign acc_e_nx = (acc_e_q << 1) + (ga_q[F] ? PW'(mag_q) : '0);
  assign acc_v_nx = (acc_v_q << 1) + (gb_q[F] ? PW'(cur_var) : '0);

  assign delta   = acc_e_q[F +: W+1];
  assign est_w   = neg_q ? (W + 1)'({cur_est[W-1], cur_est} - delta)
                         : (W + 1)'({cur_est[W-1], cur_est} + delta);
  assign var_new = acc_v_q[F +: W];

  assign more_o      = (axis_q == AX_X);
  assign out_busy_o  = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign pos_z_o     = pos_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        est_q[i] <= '0;
        var_q[i] <= ONE_W;
      end
      axis_q      <= AX_X;
      out_valid_q <= 1'b0;
    end else begin
      if (var_load_i) begin
        for (int i = 0; i < 3; i++) var_q[i] <= var_value_i;
      end
      if (in_fire_i) axis_q <= mode_i ? AX_Z : AX_X;
      if (ctrl_i.op == OP_WB) begin
        est_q[axis_q] <= est_w[W-1:0];
        var_q[axis_q] <= var_new;
        if (axis_q == AX_X) axis_q <= AX_Y;
      end
      if (ctrl_i.op == OP_OUT && !out_busy_o) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      meas_q[AX_X] <= gps_x_i;
      meas_q[AX_Y] <= gps_y_i;
      meas_q[AX_Z] <= depth_m_i;
    end
    case (ctrl_i.op)
      OP_LOAD: begin
        den_q <= {1'b0, cur_var} + {1'b0, noise};
        rem_q <= (W + 2)'(cur_var);
        quo_q <= '0;
        mag_q <= mag;
        neg_q <= res[W];
      end
      OP_DIV: begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[F-1:0], ge};
      end
      OP_MULI: begin
        ga_q    <= gain;
        gb_q    <= (F + 1)'(ONE_G - gain);
        acc_e_q <= '0;
        acc_v_q <= '0;
      end
      OP_MUL: begin
        acc_e_q <= acc_e_nx;
        acc_v_q <= acc_v_nx;
        ga_q    <= {ga_q[F-1:0], 1'b0};
        gb_q    <= {gb_q[F-1:0], 1'b0};
      end
      OP_OUT: begin
        if (!out_busy_o) begin
          pos_x_q <= est_q[AX_X];
          pos_y_q <= est_q[AX_Y];
          pos_z_q <= est_q[AX_Z];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
